// ===== rtl/b2da_pkg.sv =====
package b2da_pkg;

	// Fixed field widths of the channels
	localparam int NUMBER_IN_W = 32;
	localparam int COUNT_W     = 5;
	localparam int CHAR_W      = 6;
	localparam int BCD_DIGIT_W = 4;

	// Parameter defaults
	localparam int NUMBER_WIDTH_DEF = 32;
	localparam int MAX_DIGITS_DEF   = 16;

	// ASCII code of the character zero
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic step;
		logic emit;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic count_zero;
		logic conv_done;
		logic last_digit;
	} status_t;

endpackage

// ===== rtl/binary_to_decimal_ascii_digits.sv =====
// Binary to decimal ASCII converter.
// Input channel (in_valid/in_stall) carries number and digit_count; a request
// is taken when in_valid is high and in_stall low. The block then emits
// digit_count ASCII characters '0'..'9' on the output channel
// (out_valid/out_stall), most significant first, with last on the final one.
// These are the low decimal digits of number; leading zeros are filled in.
// A count above MAX_DIGITS saturates; a count of zero emits nothing.
// Timing: one request at a time. After acceptance the double dabble unit
// runs one shift-add-3 step per cycle over min(NUMBER_WIDTH,32) bits, then
// one character leaves per cycle while out_stall is low. The first character
// is valid once the last step has been made.
// When the receiver stalls, the current character and last hold steady and
// no new request is taken until the final character is delivered.
// Reset (arst_n low) returns the controller to idle, ready for a request,
// with out_valid low.
module binary_to_decimal_ascii_digits #(
	parameter int NUMBER_WIDTH = b2da_pkg::NUMBER_WIDTH_DEF,
	parameter int MAX_DIGITS   = b2da_pkg::MAX_DIGITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [b2da_pkg::NUMBER_IN_W-1:0] number,
	input  logic [b2da_pkg::COUNT_W-1:0]     digit_count,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [b2da_pkg::CHAR_W-1:0]      ascii_char,
	output logic                             last
);

	b2da_pkg::cmd_t    cmd;
	b2da_pkg::status_t status;

	// Sequencer
	b2da_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Conversion datapath
	b2da_datapath #(
		.NUMBER_WIDTH (NUMBER_WIDTH),
		.MAX_DIGITS   (MAX_DIGITS)
	) u_datapath (
		.clk         (clk),
		.number      (number),
		.digit_count (digit_count),
		.ascii_char  (ascii_char),
		.last        (last),
		.cmd         (cmd),
		.status      (status)
	);

endmodule

// ===== rtl/b2da_ctrl.sv =====
module b2da_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  b2da_pkg::status_t status,
	output b2da_pkg::cmd_t    cmd
);

	b2da_pkg::state_t state_q;
	b2da_pkg::state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= b2da_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			b2da_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					// zero count: nothing to emit, stay ready
					if (!status.count_zero) begin
						state_d = b2da_pkg::ST_CONV;
					end
				end
			end
			b2da_pkg::ST_CONV: begin
				cmd.step = 1'b1;
				if (status.conv_done) begin
					state_d = b2da_pkg::ST_EMIT;
				end
			end
			b2da_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					cmd.emit = 1'b1;
					if (status.last_digit) begin
						state_d = b2da_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = b2da_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/b2da_datapath.sv =====
module b2da_datapath #(
	parameter int NUMBER_WIDTH = b2da_pkg::NUMBER_WIDTH_DEF,
	parameter int MAX_DIGITS   = b2da_pkg::MAX_DIGITS_DEF
) (
	input  logic                               clk,
	input  logic [b2da_pkg::NUMBER_IN_W-1:0]   number,
	input  logic [b2da_pkg::COUNT_W-1:0]       digit_count,
	output logic [b2da_pkg::CHAR_W-1:0]        ascii_char,
	output logic                               last,
	input  b2da_pkg::cmd_t                     cmd,
	output b2da_pkg::status_t                  status
);

	// Bits that can be nonzero: the field is 32 bits wide
	localparam int CONV_W = (NUMBER_WIDTH < b2da_pkg::NUMBER_IN_W) ?
		NUMBER_WIDTH : b2da_pkg::NUMBER_IN_W;
	localparam int STEP_W = $clog2(CONV_W);
	localparam int IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int BCD_W  = MAX_DIGITS * b2da_pkg::BCD_DIGIT_W;

	logic [CONV_W-1:0]                             bin_q;
	logic [MAX_DIGITS-1:0][b2da_pkg::BCD_DIGIT_W-1:0] bcd_q;
	logic [MAX_DIGITS-1:0][b2da_pkg::BCD_DIGIT_W-1:0] adj;
	logic [BCD_W:0]                                shift_w;
	logic [STEP_W-1:0]                             step_q;
	logic [IDX_W-1:0]                              pos_q;
	logic [b2da_pkg::COUNT_W-1:0]                  cnt_sat;

	// Saturate the requested count
	assign cnt_sat = (digit_count > b2da_pkg::COUNT_W'(MAX_DIGITS)) ?
		b2da_pkg::COUNT_W'(MAX_DIGITS) : digit_count;

	// Add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	// Adjusted digits shifted left by one, next binary bit in at the bottom
	assign shift_w = {adj, bin_q[CONV_W-1]};

	// Double dabble shift registers and emit position
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q  <= number[CONV_W-1:0];
			bcd_q  <= '0;
			step_q <= STEP_W'(CONV_W - 1);
			pos_q  <= IDX_W'(cnt_sat - b2da_pkg::COUNT_W'(1));
		end else if (cmd.step) begin
			bin_q  <= {bin_q[CONV_W-2:0], 1'b0};
			bcd_q  <= shift_w[BCD_W-1:0];
			step_q <= step_q - STEP_W'(1);
		end else if (cmd.emit) begin
			pos_q <= pos_q - IDX_W'(1);
		end
	end

	// Character out of the current digit
	assign ascii_char = b2da_pkg::ASCII_ZERO +
		b2da_pkg::CHAR_W'(bcd_q[pos_q]);
	assign last       = (pos_q == '0);

	assign status.count_zero = (digit_count == '0);
	assign status.conv_done  = (step_q == '0);
	assign status.last_digit = last;

endmodule

// ===== test/tb_binary_to_decimal_ascii_digits.sv =====
module tb_binary_to_decimal_ascii_digits;

	logic                             clk         = 1'b0;
	logic                             arst_n      = 1'b0;
	logic                             in_valid    = 1'b0;
	logic                             in_stall;
	logic [b2da_pkg::NUMBER_IN_W-1:0] number      = '0;
	logic [b2da_pkg::COUNT_W-1:0]     digit_count = '0;
	logic                             out_valid;
	logic                             out_stall   = 1'b0;
	logic [b2da_pkg::CHAR_W-1:0]      ascii_char;
	logic                             last;

	// Expected characters, oldest first
	logic [b2da_pkg::CHAR_W-1:0] exp_chars[$];
	logic                        exp_lasts[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int numbers_sent   = 0;
	int chars_checked  = 0;
	int mismatch_count = 0;

	binary_to_decimal_ascii_digits uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.number      (number),
		.digit_count (digit_count),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ascii_char  (ascii_char),
		.last        (last)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	// Decimal digits of the request, low digits only, most significant first
	function automatic void push_decimal_chars(
			input logic [b2da_pkg::NUMBER_IN_W-1:0] num,
			input logic [b2da_pkg::COUNT_W-1:0] cnt);
		logic [b2da_pkg::NUMBER_IN_W-1:0] rest;
		logic [b2da_pkg::BCD_DIGIT_W-1:0] dig[20];
		int n;
		int pos;
		rest = num;
		for (int p = 0; p < 20; p++) begin
			dig[p] = b2da_pkg::BCD_DIGIT_W'(rest % 10);
			rest   = rest / 10;
		end
		n = (int'(cnt) > b2da_pkg::MAX_DIGITS_DEF) ? b2da_pkg::MAX_DIGITS_DEF : int'(cnt);
		for (int k = 0; k < n; k++) begin
			pos = n - 1 - k;
			exp_chars.push_back(b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(dig[pos]));
			exp_lasts.push_back(k == n - 1);
		end
	endfunction

	// Send one request; valid stays high into the next request when no gap is drawn
	task automatic send_number(input logic [b2da_pkg::NUMBER_IN_W-1:0] num,
			input logic [b2da_pkg::COUNT_W-1:0] cnt);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		number      <= num;
		digit_count <= cnt;
		do @(posedge clk); while (in_stall);
		push_decimal_chars(num, cnt);
		numbers_sent++;
	endtask

	task automatic wait_drained();
		while (exp_chars.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: stall at random, check each accepted character
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (exp_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected char %0d last %0b", ascii_char, last));
			end else begin
				if (ascii_char !== exp_chars[0])
					report_mismatch($sformatf("char %0d, expected %0d",
						ascii_char, exp_chars[0]));
				if (last !== exp_lasts[0])
					report_mismatch($sformatf("last %0b, expected %0b (char %0d)",
						last, exp_lasts[0], exp_chars[0]));
				void'(exp_chars.pop_front());
				void'(exp_lasts.pop_front());
				chars_checked++;
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic logic [b2da_pkg::NUMBER_IN_W-1:0] pick_number();
		logic [b2da_pkg::NUMBER_IN_W-1:0] pow;
		pow = 1;
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 99);
			1: begin
				repeat ($urandom_range(0, 9)) pow = pow * 10;
				return pow + b2da_pkg::NUMBER_IN_W'($urandom_range(0, 2)) - 1;
			end
			2: return 32'hFFFF_FFFF - b2da_pkg::NUMBER_IN_W'($urandom_range(0, 15));
			default: return $urandom;
		endcase
	endfunction

	// Mostly legal counts, some saturating ones
	function automatic logic [b2da_pkg::COUNT_W-1:0] pick_count();
		if ($urandom_range(0, 9) == 0)
			return b2da_pkg::COUNT_W'($urandom_range(17, 31));
		return b2da_pkg::COUNT_W'($urandom_range(0, 16));
	endfunction

	task automatic run_random_numbers(input int n);
		for (int i = 0; i < n; i++)
			send_number(pick_number(), pick_count());
	endtask

	// Extremes, saturating counts, zero counts, digits past the tenth
	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_number(32'd0, 5'd1);
		send_number(32'd0, 5'd0);
		send_number(32'hFFFF_FFFF, 5'd16);
		send_number(32'hFFFF_FFFF, 5'd10);
		send_number(32'hFFFF_FFFF, 5'd31);
		send_number(32'hFFFF_FFFF, 5'd17);
		send_number(32'd123456789, 5'd5);
		send_number(32'd1234567890, 5'd10);
		send_number(32'd1234567890, 5'd11);
		send_number(32'd9, 5'd1);
		send_number(32'd10, 5'd1);
		send_number(32'd999999999, 5'd9);
		send_number(32'd1000000000, 5'd16);
		send_number(32'd42, 5'd0);
		send_number(32'd7, 5'd3);
		send_number(32'h8000_0000, 5'd12);
		send_number(32'hFFFF_FFFF, 5'd1);
		send_number(32'd1, 5'd16);
		send_number(32'hAAAA_AAAA, 5'd8);
		send_number(32'h5555_5555, 5'd20);
		send_number(32'd0, 5'd31);
		send_number(32'd9999, 5'd4);
		send_number(32'd0, 5'd0);
		send_number(32'd65535, 5'd2);
	endtask

	task automatic test_back_to_back();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_random_numbers(20);
	endtask

	task automatic test_sender_idle();
		send_idle_pct  = 86;
		recv_stall_pct = 0;
		run_random_numbers(20);
	endtask

	task automatic test_receiver_stall();
		send_idle_pct  = 0;
		recv_stall_pct = 86;
		run_random_numbers(20);
	endtask

	task automatic test_both_idle();
		send_idle_pct  = 36;
		recv_stall_pct = 36;
		run_random_numbers(20);
	endtask

	// Sender holds off until every character has been delivered
	task automatic test_drain_pause();
		send_idle_pct  = 0;
		recv_stall_pct = 36;
		run_random_numbers(4);
		in_valid <= 1'b0;
		wait_drained();
		@(posedge clk);
		run_random_numbers(4);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_back_to_back();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_drain_pause();
		in_valid <= 1'b0;
		wait_drained();
		repeat (60) @(posedge clk);
		if (exp_chars.size() != 0)
			report_mismatch($sformatf("%0d chars never arrived", exp_chars.size()));
		$display("Converted %0d numbers (counts 0..31, extremes, idle and stall mixes),",
			numbers_sent);
		$display("checked %0d ASCII characters with their last flags.", chars_checked);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog
	initial begin
		#(8 * 200000);
		$display("Timeout waiting for the converter");
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/b2da_pkg.sv
rtl/b2da_ctrl.sv
rtl/b2da_datapath.sv
rtl/binary_to_decimal_ascii_digits.sv
test/tb_binary_to_decimal_ascii_digits.sv
